>>> hdl/gcbf_pkg.sv
package gcbf_pkg;

  localparam int unsigned FONT_BYTES_DEFAULT = 4096;

  localparam int unsigned HDR_HEIGHT  = 3;
  localparam int unsigned HDR_FIRST   = 4;
  localparam int unsigned HDR_COUNT   = 5;
  localparam int unsigned WIDTH_TABLE = 6;

  localparam int unsigned FULL_AW = 18;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_FETCH = 1'b1
  } op_e;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_CHECK    = 9'b000000010,
    S_WIDTH    = 9'b000000100,
    S_WALK_RD  = 9'b000001000,
    S_WALK_ACC = 9'b000010000,
    S_ADDR     = 9'b000100000,
    S_DATA0    = 9'b001000000,
    S_DATA1    = 9'b010000000,
    S_RESULT   = 9'b100000000
  } state_e;

endpackage

>>> hdl/glyph_column_byte_fetch.sv
// Glyph column byte fetch.
// Input channel (in_valid_i / in_ready_o) takes one word per item: a write of
// one font image byte (operation 0) or a fetch of one glyph column byte
// (operation 1). Output channel (out_valid_o / out_ready_i) returns one word
// per item: pixel_byte_o, zero for writes and for fetches out of range.
// The image lives in a single-port store of FONT_BYTES bytes (a power of two)
// with registered read data; header bytes 3, 4 and 5 are shadowed in
// registers as they are written.
// A write goes straight to the result state; a fetch failing its range
// checks stops after the index check or width read; with a cached glyph
// start it then reads one or two image bytes. A miss first walks the width
// table via the one store read port and the shared multiply-add unit that
// sums the widths, one read per earlier character. One item is in flight
// at a time; in_ready_o is high only while idle, so with the output free the
// next item is taken at the edge where the prior result can first be taken.
// The output register holds a finished result while the receiver stalls, and
// the block still takes the next item; the next result then waits for the
// register to drain. Reset empties the output, clears the start cache and
// leaves the store contents undefined until written.
module glyph_column_byte_fetch
  import gcbf_pkg::*;
#(
  parameter int unsigned FONT_BYTES = FONT_BYTES_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [11:0] image_address_i,
  input  logic [7:0]  image_data_i,
  input  logic [7:0]  character_i,
  input  logic [7:0]  column_i,
  input  logic [7:0]  row_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  pixel_byte_o
);

  localparam int unsigned AW = $clog2(FONT_BYTES);

  logic [7:0] mem_q [FONT_BYTES];

  state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  pix_q, pix_d;
  logic        cache_valid_q, cache_valid_d;
  logic [7:0]  cached_char_q, cached_char_d;
  logic [15:0] cached_start_q, cached_start_d;

  logic [7:0]  height_q, height_d;
  logic [7:0]  first_q, first_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  ch_q, ch_d;
  logic [7:0]  col_q, col_d;
  logic [7:0]  off_q, off_d;
  logic [7:0]  width_q, width_d;
  logic [7:0]  idx_q, idx_d;
  logic [7:0]  i_q, i_d;
  logic [15:0] pos_q, pos_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [7:0]  byte0_q, byte0_d;
  logic [7:0]  res_q, res_d;
  logic [7:0]  rdata_q;

  logic          mem_we, mem_re;
  logic [AW-1:0] waddr, raddr;
  logic [FULL_AW-1:0] waddr_full, wdt_full, walk_full, a0_full;
  logic        accept;
  logic [5:0]  bpc;
  logic [2:0]  pad;
  logic [4:0]  q;
  logic [2:0]  r;
  logic        q_last, q_next_last;
  logic [8:0]  first_sum;
  logic        in_range;
  logic [7:0]  idx_cmb;
  logic [7:0]  mul_a;
  logic [5:0]  mul_b;
  logic [13:0] prod;
  logic [7:0]  nxt;
  logic [15:0] nxt_wide;
  logic [3:0]  sh0;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  assign bpc         = 6'((9'(height_q) + 9'd7) >> 3);
  assign pad         = 3'(3'd0 - height_q[2:0]);
  assign q           = off_q[7:3];
  assign r           = off_q[2:0];
  assign q_last      = ({1'b0, q} == (bpc - 6'd1));
  assign q_next_last = (({1'b0, q} + 6'd1) == (bpc - 6'd1));
  assign first_sum   = {1'b0, first_q} + {1'b0, count_q};
  assign in_range    = (ch_q >= first_q) && ({1'b0, ch_q} < first_sum);
  assign idx_cmb     = ch_q - first_q;

  assign mul_a = (state_q == S_WALK_ACC) ? rdata_q : width_q;
  assign mul_b = (state_q == S_WALK_ACC) ? bpc : {1'b0, q};
  assign prod  = {6'd0, mul_a} * {8'd0, mul_b};

  assign waddr_full = FULL_AW'(image_address_i);
  assign waddr      = waddr_full[AW-1:0];
  assign wdt_full   = FULL_AW'(idx_cmb) + FULL_AW'(WIDTH_TABLE);
  assign walk_full  = FULL_AW'(i_q) + FULL_AW'(WIDTH_TABLE);
  assign a0_full    = FULL_AW'(pos_q) + FULL_AW'(col_q) + FULL_AW'(prod);

  assign sh0      = {1'b0, r} + {1'b0, pad};
  assign nxt      = q_next_last ? (rdata_q >> pad) : rdata_q;
  assign nxt_wide = {8'd0, nxt} << (4'd8 - {1'b0, r});

  always_comb begin
    state_d        = state_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    pix_d          = pix_q;
    cache_valid_d  = cache_valid_q;
    cached_char_d  = cached_char_q;
    cached_start_d = cached_start_q;
    height_d       = height_q;
    first_d        = first_q;
    count_d        = count_q;
    ch_d           = ch_q;
    col_d          = col_q;
    off_d          = off_q;
    width_d        = width_q;
    idx_d          = idx_q;
    i_d            = i_q;
    pos_d          = pos_q;
    addr_d         = addr_q;
    byte0_d        = byte0_q;
    res_d          = res_q;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    raddr          = wdt_full[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (op_e'(operation_i) == OP_WRITE) begin
            mem_we        = 1'b1;
            cache_valid_d = 1'b0;
            res_d         = 8'd0;
            if (waddr == AW'(HDR_HEIGHT)) height_d = image_data_i;
            if (waddr == AW'(HDR_FIRST))  first_d  = image_data_i;
            if (waddr == AW'(HDR_COUNT))  count_d  = image_data_i;
            state_d = S_RESULT;
          end else begin
            ch_d    = character_i;
            col_d   = column_i;
            off_d   = row_offset_i;
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (!in_range) begin
          res_d   = 8'd0;
          state_d = S_RESULT;
        end else begin
          mem_re  = 1'b1;
          raddr   = wdt_full[AW-1:0];
          idx_d   = idx_cmb;
          state_d = S_WIDTH;
        end
      end
      S_WIDTH: begin
        width_d = rdata_q;
        if ((col_q >= rdata_q) || (off_q >= height_q)) begin
          res_d   = 8'd0;
          state_d = S_RESULT;
        end else if (cache_valid_q && (cached_char_q == ch_q)) begin
          pos_d   = cached_start_q;
          state_d = S_ADDR;
        end else begin
          pos_d   = 16'(count_q) + 16'(WIDTH_TABLE);
          i_d     = 8'd0;
          state_d = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        if (i_q == idx_q) begin
          cache_valid_d  = 1'b1;
          cached_char_d  = ch_q;
          cached_start_d = pos_q;
          state_d        = S_ADDR;
        end else begin
          mem_re  = 1'b1;
          raddr   = walk_full[AW-1:0];
          i_d     = i_q + 8'd1;
          state_d = S_WALK_ACC;
        end
      end
      S_WALK_ACC: begin
        pos_d   = pos_q + 16'(prod);
        state_d = S_WALK_RD;
      end
      S_ADDR: begin
        mem_re  = 1'b1;
        raddr   = a0_full[AW-1:0];
        addr_d  = a0_full[AW-1:0];
        state_d = S_DATA0;
      end
      S_DATA0: begin
        byte0_d = rdata_q;
        if (q_last) begin
          res_d   = rdata_q >> sh0;
          state_d = S_RESULT;
        end else begin
          mem_re  = 1'b1;
          raddr   = addr_q + AW'(width_q);
          state_d = S_DATA1;
        end
      end
      S_DATA1: begin
        res_d   = (byte0_q >> r) | nxt_wide[7:0];
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          pix_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      out_valid_q    <= 1'b0;
      cache_valid_q  <= 1'b0;
      cached_char_q  <= 8'd0;
      cached_start_q <= 16'd0;
    end else begin
      state_q        <= state_d;
      out_valid_q    <= out_valid_d;
      cache_valid_q  <= cache_valid_d;
      cached_char_q  <= cached_char_d;
      cached_start_q <= cached_start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q    <= pix_d;
    height_q <= height_d;
    first_q  <= first_d;
    count_q  <= count_d;
    ch_q     <= ch_d;
    col_q    <= col_d;
    off_q    <= off_d;
    width_q  <= width_d;
    idx_q    <= idx_d;
    i_q      <= i_d;
    pos_q    <= pos_d;
    addr_q   <= addr_d;
    byte0_q  <= byte0_d;
    res_q    <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= image_data_i;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_byte_o = pix_q;

  a_write_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op_e'(operation_i) == OP_WRITE))
      |=> (state_q == S_RESULT) && (res_q == 8'd0))
    else $error("write item did not queue a zero result");

  a_write_drops_cache: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op_e'(operation_i) == OP_WRITE)) |=> !cache_valid_q)
    else $error("start cache survived a write");

  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK_RD) |-> (i_q <= idx_q))
    else $error("width walk ran past the character index");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT && out_valid_q && !out_ready_i)
      |=> (state_q == S_RESULT) && $stable(pixel_byte_o))
    else $error("result overwrote an undelivered word");

endmodule
